[rtl/grnn_pkg.sv]
// Package for the GRNN kernel regression unit: field widths and codes.
`timescale 1ns / 1ps
package grnn_pkg;

    // Input opcodes (tuser)
    localparam logic [1:0] OP_FEATURE  = 2'd0;
    localparam logic [1:0] OP_TARGET   = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Register indexes on the APB port
    localparam logic [1:0] REG_INV_TWO_SIGMA_SQ = 2'd0;
    localparam logic [1:0] REG_TRAIN_COUNT      = 2'd1;
    localparam logic [1:0] REG_DETECTOR_COUNT   = 2'd2;
    localparam logic [1:0] REG_GROUP_COUNT      = 2'd3;

    // Register reset values
    localparam logic [31:0] RST_INV_TWO_SIGMA_SQ = 32'd1456356;
    localparam logic [8:0]  RST_TRAIN_COUNT      = 9'd188;
    localparam logic [4:0]  RST_DETECTOR_COUNT   = 5'd8;
    localparam logic [6:0]  RST_GROUP_COUNT      = 7'd53;

    // Field widths
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned ELEM_W   = 6;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned GROUP_W  = 6;
    localparam int unsigned WEIGHT_W = 16;

endpackage

[rtl/grnn_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module grnn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[rtl/grnn_kernel_regression_unit.sv]
// Top level of the GRNN kernel regression unit.
`timescale 1ns / 1ps
// Training feature words (opcode 0) and target words (opcode 1) are written into
// block RAM, one per cycle, and query elements (opcode 2) are taken one per cycle.
// The query element carrying tlast starts a prediction run if group_count is not
// zero, during which no input transaction is accepted: each of the train_count
// samples is processed with one feature read and one target read-modify-write of
// the numerator RAM per cycle, and each of the group_count results is then formed
// by the 32-step restoring divider (bypassed when the weight sum is zero or the
// quotient saturates) and held until i_m_tready. After reset the exponential
// table is built into its RAM one entry per cycle, so no item is accepted until
// the table is complete; register writes are taken at any time.
module grnn_kernel_regression_unit
    import grnn_pkg::*;
#(
    parameter int MAX_TRAIN       = 256,
    parameter int MAX_DETECTORS   = 16,
    parameter int MAX_GROUPS      = 64,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // sample_index[7:0], element_index[13:8], value[45:14]
    input  logic [1:0]  i_s_tuser,  // opcode[1:0]
    input  logic        i_s_tlast,  // last_element
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // group_index[5:0], prediction[37:6]
    output logic [0:0]  o_m_tuser,  // no_weight[0]
    output logic        o_m_tlast,  // last_group
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SI_W = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
    localparam int DI_W = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1;
    localparam int GI_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int EW   = $clog2(EXP_TABLE_DEPTH);
    localparam int NT_W = $clog2(MAX_TRAIN + 1);
    localparam int DC_W = $clog2(MAX_DETECTORS + 1);
    localparam int GC_W = $clog2(MAX_GROUPS + 1);

    // Exponential step factor r = exp(-16/DEPTH) in Q0.32, Taylor series
    localparam logic [63:0] T0  = 64'd1 << 32;
    localparam logic [63:0] H   = (64'd1 << 36) / EXP_TABLE_DEPTH;
    localparam logic [63:0] T1  = ((T0 * H) >> 32) / 1;
    localparam logic [63:0] T2  = ((T1 * H) >> 32) / 2;
    localparam logic [63:0] T3  = ((T2 * H) >> 32) / 3;
    localparam logic [63:0] T4  = ((T3 * H) >> 32) / 4;
    localparam logic [63:0] T5  = ((T4 * H) >> 32) / 5;
    localparam logic [63:0] T6  = ((T5 * H) >> 32) / 6;
    localparam logic [63:0] T7  = ((T6 * H) >> 32) / 7;
    localparam logic [63:0] T8  = ((T7 * H) >> 32) / 8;
    localparam logic [63:0] T9  = ((T8 * H) >> 32) / 9;
    localparam logic [63:0] T10 = ((T9 * H) >> 32) / 10;
    localparam logic [63:0] T11 = ((T10 * H) >> 32) / 11;
    localparam logic [63:0] T12 = ((T11 * H) >> 32) / 12;
    localparam logic [63:0] T13 = ((T12 * H) >> 32) / 13;
    localparam logic [63:0] T14 = ((T13 * H) >> 32) / 14;
    localparam logic [63:0] T15 = ((T14 * H) >> 32) / 15;
    localparam logic [63:0] T16 = ((T15 * H) >> 32) / 16;
    localparam logic [63:0] POS = T0 + T2 + T4 + T6 + T8 + T10 + T12 + T14 + T16;
    localparam logic [63:0] NEG = T1 + T3 + T5 + T7 + T9 + T11 + T13 + T15;
    localparam logic [63:0] R64 = POS - NEG;
    localparam logic [31:0] R_STEP = R64[31:0];
    localparam logic [12:0] DEPTH_C = 13'(EXP_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIST, S_WT, S_ACC, S_OUTRD, S_LOAD, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [31:0] r_k;
    logic [8:0]  r_tc;
    logic [4:0]  r_dc;
    logic [6:0]  r_gc;

    // Run counters and accumulators
    logic [NT_W-1:0] r_ntrain, r_s;
    logic [DC_W-1:0] r_dets, r_j;
    logic [GC_W-1:0] r_groups, r_g;
    logic [GI_W-1:0] r_ag;
    logic            r_v1, r_v2, r_av;
    logic [63:0]     r_sq, r_d2;
    logic [2:0]      r_wstep;
    logic            r_big, r_wzero;
    logic [49:0]     r_pp_lo, r_pp_hi;
    logic [67:0]     r_a;
    logic [EW-1:0]   r_idx;
    logic [15:0]     r_w;
    logic [31:0]     r_ws;
    logic [31:0]     r_rem, r_q;
    logic [5:0]      r_dcnt;
    logic [EW:0]     r_e;
    logic [32:0]     r_acc;

    // Output registers
    logic            r_out_valid;
    logic [5:0]      r_out_group;
    logic [31:0]     r_out_pred;
    logic            r_out_nw;
    logic            r_out_last;

    // Input fields
    logic [1:0]  in_op;
    logic [31:0] in_si, in_ei;
    logic [31:0] in_val;
    logic        in_acc;

    assign in_op  = i_s_tuser;
    assign in_si  = 32'(i_s_tdata[7:0]);
    assign in_ei  = 32'(i_s_tdata[13:8]);
    assign in_val = i_s_tdata[45:14];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc = i_s_tvalid && o_s_tready;

    // APB
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_INV_TWO_SIGMA_SQ: prdata = r_k;
            REG_TRAIN_COUNT:      prdata = 32'(r_tc);
            REG_DETECTOR_COUNT:   prdata = 32'(r_dc);
            REG_GROUP_COUNT:      prdata = 32'(r_gc);
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= RST_INV_TWO_SIGMA_SQ;
            r_tc <= RST_TRAIN_COUNT;
            r_dc <= RST_DETECTOR_COUNT;
            r_gc <= RST_GROUP_COUNT;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_INV_TWO_SIGMA_SQ: r_k  <= pwdata;
                REG_TRAIN_COUNT:      r_tc <= pwdata[8:0];
                REG_DETECTOR_COUNT:   r_dc <= pwdata[4:0];
                REG_GROUP_COUNT:      r_gc <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Memories
    logic                 feat_we, tgt_we, qry_we, num_we, exp_we;
    logic [31:0]          feat_rd, tgt_rd, qry_rd;
    logic [63:0]          num_rd, num_wd;
    logic [15:0]          exp_rd, exp_wd;
    logic [SI_W+DI_W-1:0] feat_waddr, feat_raddr;
    logic [SI_W+GI_W-1:0] tgt_waddr, tgt_raddr;
    logic                 iss_d, iss_g;

    assign feat_we = in_acc && (in_op == OP_FEATURE) && (in_si < 32'(MAX_TRAIN))
                     && (in_ei < 32'(MAX_DETECTORS));
    assign tgt_we  = in_acc && (in_op == OP_TARGET) && (in_si < 32'(MAX_TRAIN))
                     && (in_ei < 32'(MAX_GROUPS));
    assign qry_we  = in_acc && (in_op == OP_QUERY) && (in_ei < 32'(MAX_DETECTORS));

    assign feat_waddr = {in_si[SI_W-1:0], in_ei[DI_W-1:0]};
    assign feat_raddr = {r_s[SI_W-1:0], r_j[DI_W-1:0]};
    assign tgt_waddr  = {in_si[SI_W-1:0], in_ei[GI_W-1:0]};
    assign tgt_raddr  = {r_s[SI_W-1:0], r_g[GI_W-1:0]};

    grnn_ram #(.WIDTH(32), .DEPTH(2 ** (SI_W + DI_W))) u_feat_ram (
        .i_clk(i_clk), .i_we(feat_we), .i_waddr(feat_waddr), .i_wdata(in_val),
        .i_raddr(feat_raddr), .o_rdata(feat_rd)
    );

    grnn_ram #(.WIDTH(32), .DEPTH(2 ** (SI_W + GI_W))) u_tgt_ram (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_waddr), .i_wdata(in_val),
        .i_raddr(tgt_raddr), .o_rdata(tgt_rd)
    );

    grnn_ram #(.WIDTH(32), .DEPTH(2 ** DI_W)) u_qry_ram (
        .i_clk(i_clk), .i_we(qry_we), .i_waddr(in_ei[DI_W-1:0]), .i_wdata(in_val),
        .i_raddr(r_j[DI_W-1:0]), .o_rdata(qry_rd)
    );

    grnn_ram #(.WIDTH(64), .DEPTH(2 ** GI_W)) u_num_ram (
        .i_clk(i_clk), .i_we(num_we), .i_waddr(r_ag), .i_wdata(num_wd),
        .i_raddr(r_g[GI_W-1:0]), .o_rdata(num_rd)
    );

    grnn_ram #(.WIDTH(16), .DEPTH(2 ** EW)) u_exp_ram (
        .i_clk(i_clk), .i_we(exp_we), .i_waddr(r_e[EW-1:0]), .i_wdata(exp_wd),
        .i_raddr(r_idx), .o_rdata(exp_rd)
    );

    // Exponential table build
    logic [64:0] acc_prod;
    logic [32:0] exp_round;
    assign exp_we    = (r_state == S_INIT) && (r_e < (EW + 1)'(EXP_TABLE_DEPTH));
    assign exp_round = r_acc + 33'h8000;
    assign exp_wd    = (exp_round[32:16] > 17'd65535) ? 16'hFFFF : exp_round[31:16];
    assign acc_prod  = r_acc * R_STEP;

    // Distance: absolute difference and its square
    logic [31:0] diff;
    assign iss_d = (r_state == S_DIST) && (r_j < r_dets);
    assign diff  = (qry_rd >= feat_rd) ? (qry_rd - feat_rd) : (feat_rd - qry_rd);

    // Numerator read-modify-write; the first sample starts from zero
    logic [63:0] num_old;
    assign iss_g   = (r_state == S_ACC) && (r_g < r_groups);
    assign num_old = (r_s == '0) ? 64'd0 : num_rd;
    assign num_we  = r_av;
    assign num_wd  = num_old + (64'(r_w) * 64'(tgt_rd));

    // Exponent argument and table index
    logic [48:0] idx_prod;
    assign idx_prod = r_a[35:0] * DEPTH_C;

    // Divider step
    logic [32:0] rem2;
    logic        rem_ge;
    assign rem2   = {r_rem, r_q[31]};
    assign rem_ge = rem2 >= {1'b0, r_ws};

    // Clamped counts
    logic [NT_W-1:0] ntrain_c;
    logic [DC_W-1:0] dets_c;
    logic [GC_W-1:0] groups_c;
    assign ntrain_c = (32'(r_tc) > 32'(MAX_TRAIN)) ? NT_W'(MAX_TRAIN) : NT_W'(r_tc);
    assign dets_c   = (32'(r_dc) > 32'(MAX_DETECTORS)) ? DC_W'(MAX_DETECTORS) : DC_W'(r_dc);
    assign groups_c = (32'(r_gc) > 32'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS) : GC_W'(r_gc);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_e         <= '0;
            r_acc       <= 33'h1_0000_0000;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_av        <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_e   <= r_e + 1'b1;
                    r_acc <= acc_prod[64:32];
                    if (!exp_we) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (in_op == OP_QUERY) && i_s_tlast) begin
                        r_ntrain <= ntrain_c;
                        r_dets   <= dets_c;
                        r_groups <= groups_c;
                        r_s      <= '0;
                        r_j      <= '0;
                        r_g      <= '0;
                        r_d2     <= '0;
                        r_ws     <= '0;
                        if (groups_c == '0) begin
                            r_state <= S_IDLE;
                        end else if (ntrain_c == '0) begin
                            r_state <= S_OUTRD;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    r_v1 <= iss_d;
                    r_v2 <= r_v1;
                    if (iss_d) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_v1) begin
                        r_sq <= diff * diff;
                    end
                    if (r_v2) begin
                        r_d2 <= r_d2 + (r_sq >> 16);
                    end
                    if (!iss_d && !r_v1 && !r_v2) begin
                        r_wstep <= '0;
                        r_state <= S_WT;
                    end
                end
                S_WT: begin
                    r_wstep <= r_wstep + 1'b1;
                    case (r_wstep)
                        3'd0: begin
                            r_big   <= (r_d2[63:36] != '0) && (r_k != '0);
                            r_pp_lo <= r_d2[17:0] * r_k;
                            r_pp_hi <= r_d2[35:18] * r_k;
                        end
                        3'd1: r_a <= (68'(r_pp_hi) << 18) + 68'(r_pp_lo);
                        3'd2: begin
                            r_wzero <= r_big || (r_a[67:36] != '0);
                            r_idx   <= idx_prod[36+EW-1:36];
                        end
                        3'd3: ;
                        default: begin
                            r_w     <= r_wzero ? 16'd0 : exp_rd;
                            r_ws    <= r_ws + (r_wzero ? 32'd0 : 32'(exp_rd));
                            r_g     <= '0;
                            r_state <= S_ACC;
                        end
                    endcase
                end
                S_ACC: begin
                    r_av <= iss_g;
                    r_ag <= r_g[GI_W-1:0];
                    if (iss_g) begin
                        r_g <= r_g + 1'b1;
                    end
                    if (!iss_g && !r_av) begin
                        r_s  <= r_s + 1'b1;
                        r_j  <= '0;
                        r_d2 <= '0;
                        r_g  <= '0;
                        if (r_s + 1'b1 == r_ntrain) begin
                            r_state <= S_OUTRD;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_OUTRD: r_state <= S_LOAD;
                S_LOAD: begin
                    r_out_group <= 6'(r_g);
                    r_out_last  <= (r_g + 1'b1 == r_groups);
                    if (r_ws == '0) begin
                        r_out_pred  <= '0;
                        r_out_nw    <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (num_rd[63:32] >= r_ws) begin
                        r_out_pred  <= 32'hFFFF_FFFF;
                        r_out_nw    <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_rem   <= num_rd[63:32];
                        r_q     <= num_rd[31:0];
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? 32'(rem2 - {1'b0, r_ws}) : rem2[31:0];
                    r_q    <= {r_q[30:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd31) begin
                        r_out_pred  <= {r_q[30:0], rem_ge};
                        r_out_nw    <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                        r_g         <= r_g + 1'b1;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_OUTRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output port
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_pred, r_out_group};
    assign o_m_tuser  = r_out_nw;
    assign o_m_tlast  = r_out_last;

endmodule

[test/grnn_checker.sv]
// Checker for the GRNN kernel regression unit: tracks state, predicts and compares results.
`timescale 1ns / 1ps
module grnn_checker
    import grnn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // sample_index[7:0], element_index[13:8], value[45:14]
    input  logic [1:0]  i_s_tuser,  // opcode[1:0]
    input  logic        i_s_tlast,  // last_element
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] o_m_tdata,  // group_index[5:0], prediction[37:6]
    input  logic [0:0]  o_m_tuser,  // no_weight[0]
    input  logic        o_m_tlast,  // last_group
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [5:0]  group;
        logic [31:0] prediction;
        logic        no_weight;
        logic        last_group;
    } t_group_result;

    // Expected results in order; a run never leaves more than 64 waiting
    t_group_result expected_ring [128];
    int            wr_count = 0;
    int            rd_count = 0;

    logic [15:0] exp_lut [1024];
    logic [31:0] feature_store [256][16];
    logic [31:0] target_store [256][64];
    logic [31:0] query_store [16];

    logic [31:0] kernel_scale;
    logic [8:0]  train_reg;
    logic [4:0]  det_reg;
    logic [6:0]  group_reg;

    // Exponential table: Taylor step factor, then repeated multiplication
    initial begin
        logic [63:0] h, t, pos, neg, r, acc, e;
        h = (64'd1 << 36) / 64'd1024;
        t = 64'd1 << 32;
        pos = t;
        neg = 0;
        for (int n = 1; n <= 16; n++) begin
            t = ((t * h) >> 32) / n;
            if (n % 2) neg += t; else pos += t;
        end
        r = pos - neg;
        acc = 64'd1 << 32;
        for (int i = 0; i < 1024; i++) begin
            if (i > 0) acc = (acc * r) >> 32;
            e = (acc + 64'h8000) >> 16;
            exp_lut[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
    end

    // Gaussian weight of one sample against the held query
    function automatic logic [15:0] kernel_weight(int s, int dets);
        logic [63:0]  d2, diff;
        logic [127:0] arg;
        d2 = 0;
        for (int j = 0; j < dets; j++) begin
            if (query_store[j] >= feature_store[s][j])
                diff = {32'd0, query_store[j] - feature_store[s][j]};
            else
                diff = {32'd0, feature_store[s][j] - query_store[j]};
            d2 += (diff * diff) >> 16;
        end
        arg = {64'd0, d2} * {96'd0, kernel_scale};
        if (arg[127:64] != 0 || arg[63:32] >= 16) return 16'd0;
        return exp_lut[arg[35:26]];
    endfunction

    // Weighted mean per energy group, queued in group order
    task automatic predict_groups();
        logic [63:0]   numer [64];
        logic [31:0]   wsum;
        logic [15:0]   w;
        logic [63:0]   quot;
        int            n_train, dets, groups;
        t_group_result res;
        n_train = (train_reg > 256) ? 256 : train_reg;
        dets = (det_reg > 16) ? 16 : det_reg;
        groups = (group_reg > 64) ? 64 : group_reg;
        wsum = 0;
        for (int g = 0; g < 64; g++) numer[g] = 0;
        for (int s = 0; s < n_train; s++) begin
            w = kernel_weight(s, dets);
            wsum += w;
            for (int g = 0; g < groups; g++)
                numer[g] += {48'd0, w} * {32'd0, target_store[s][g]};
        end
        for (int g = 0; g < groups; g++) begin
            res.group = g[5:0];
            res.no_weight = (wsum == 0);
            res.last_group = (g + 1 == groups);
            if (wsum == 0) begin
                res.prediction = 0;
            end else begin
                quot = numer[g] / wsum;
                res.prediction = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            end
            expected_ring[wr_count % 128] = res;
            wr_count++;
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        o_fail_count++;
    endtask

    // Register writes, input transactions and result transactions
    always @(posedge i_clk) begin
        logic [1:0]    op;
        logic [7:0]    si;
        logic [5:0]    ei;
        logic [31:0]   val;
        t_group_result want;
        if (!i_rst_n) begin
            kernel_scale = RST_INV_TWO_SIGMA_SQ;
            train_reg = RST_TRAIN_COUNT;
            det_reg = RST_DETECTOR_COUNT;
            group_reg = RST_GROUP_COUNT;
            o_fail_count = 0;
            wr_count = 0;
            rd_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_INV_TWO_SIGMA_SQ: kernel_scale = pwdata;
                    REG_TRAIN_COUNT:      train_reg = pwdata[8:0];
                    REG_DETECTOR_COUNT:   det_reg = pwdata[4:0];
                    REG_GROUP_COUNT:      group_reg = pwdata[6:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                op = i_s_tuser;
                si = i_s_tdata[7:0];
                ei = i_s_tdata[13:8];
                val = i_s_tdata[45:14];
                case (op)
                    OP_FEATURE: if (ei < 16) feature_store[si][ei] = val;
                    OP_TARGET:  target_store[si][ei] = val;
                    OP_QUERY: begin
                        if (ei < 16) query_store[ei] = val;
                        if (i_s_tlast) predict_groups();
                    end
                    default: ;
                endcase
            end
            if (o_m_tvalid && i_m_tready) begin
                if (wr_count == rd_count) begin
                    report("unexpected result", o_m_tdata, 0);
                end else begin
                    want = expected_ring[rd_count % 128];
                    rd_count++;
                    if (o_m_tdata[5:0] != want.group)
                        report("group_index", o_m_tdata[5:0], want.group);
                    if (o_m_tdata[37:6] != want.prediction)
                        report("prediction", o_m_tdata[37:6], want.prediction);
                    if (o_m_tuser[0] != want.no_weight)
                        report("no_weight", o_m_tuser[0], want.no_weight);
                    if (o_m_tlast != want.last_group)
                        report("last_group", o_m_tlast, want.last_group);
                end
            end
        end
        o_pending = wr_count - rd_count;
    end

endmodule

[test/tb.sv]
// Testbench top for the GRNN kernel regression unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;
    import grnn_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = OP_FEATURE;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic [0:0]  m_user;
    logic        m_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int stall_watch = 0;
    bit no_gaps = 1'b0;
    bit hold_long = 1'b0;

    // Shadow of the register settings, used to size the idle waits and the random queries
    int sh_train = RST_TRAIN_COUNT;
    int sh_det = RST_DETECTOR_COUNT;
    int sh_grp = RST_GROUP_COUNT;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    grnn_kernel_regression_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .i_s_tlast(s_last),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user), .o_m_tlast(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    grnn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .i_s_tlast(s_last),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user), .o_m_tlast(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_watch <= 0;
        end else if (stall_watch >= 80000) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_watch <= stall_watch + 1;
        end
    end

    // Result receiver with random stalls and one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_long = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    // Feature or query value clustered so that kernel weights are non-zero
    function automatic logic [31:0] near_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'h0001_0000 + $urandom_range(0, 16'h1000);
    endfunction

    task automatic send(logic [1:0] op, logic [7:0] si, logic [5:0] ei,
                        logic [31:0] val, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {2'b00, val, ei, si};
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic send_query(int n);
        int cnt;
        cnt = (n < 1) ? 1 : ((n > 16) ? 16 : n);
        for (int e = 0; e < cnt; e++)
            send(OP_QUERY, 8'($urandom), e[5:0], near_value(), e == cnt - 1);
    endtask

    // Wait for all results, then for the worst-case run time of the current settings
    task automatic wait_idle();
        int tc, dc, gc;
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        tc = (sh_train > 256) ? 256 : sh_train;
        dc = (sh_det > 16) ? 16 : sh_det;
        gc = (sh_grp > 64) ? 64 : sh_grp;
        repeat (tc * (dc + gc + 10) + gc * 40 + 64) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TRAIN_COUNT:    sh_train = val[8:0];
            REG_DETECTOR_COUNT: sh_det = val[4:0];
            REG_GROUP_COUNT:    sh_grp = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(int tc, int dc, int gc);
        cfg_write(REG_TRAIN_COUNT, 32'(tc));
        cfg_write(REG_DETECTOR_COUNT, 32'(dc));
        cfg_write(REG_GROUP_COUNT, 32'(gc));
    endtask

    initial begin
        int nwr;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small store in use; every entry that a run reads is loaded first
        set_sizes(4, 4, 4);
        no_gaps = 1'b1;
        for (int s = 0; s < 4; s++)
            for (int j = 0; j < 4; j++)
                send(OP_FEATURE, 8'(s), 6'(j), near_value(), 1'b0);
        for (int j = 4; j < 16; j++)
            send(OP_FEATURE, 8'd0, 6'(j), near_value(), 1'b0);
        for (int s = 0; s < 4; s++)
            for (int g = 0; g < 4; g++)
                send(OP_TARGET, 8'(s), 6'(g), $urandom, 1'b0);
        no_gaps = 1'b0;

        // Receiver held off while the sender keeps offering
        hold_long = 1'b1;
        send_query(4);
        send(OP_FEATURE, 8'd3, 6'd2, near_value(), 1'b0);
        wait_idle();

        // Full kernel weight, field extremes on the query
        cfg_write(REG_INV_TWO_SIGMA_SQ, 32'd0);
        send(OP_QUERY, 8'hFF, 6'd0, 32'd0, 1'b0);
        send(OP_QUERY, 8'h00, 6'd1, 32'hFFFF_FFFF, 1'b0);
        send(OP_QUERY, 8'h00, 6'd2, near_value(), 1'b0);
        send(OP_QUERY, 8'h00, 6'd3, near_value(), 1'b1);
        wait_idle();

        // Largest scale; ignored opcode, out-of-range and last flags on loads
        cfg_write(REG_INV_TWO_SIGMA_SQ, 32'hFFFF_FFFF);
        send(OP_RESERVED, 8'h55, 6'd1, 32'hAAAA_AAAA, 1'b1);
        send(OP_FEATURE, 8'h02, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send(OP_TARGET, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send(OP_QUERY, 8'h00, 6'd40, 32'h1234_5678, 1'b1);
        wait_idle();

        // Zero train count with an oversized group count: every group has no weight
        cfg_write(REG_INV_TWO_SIGMA_SQ, RST_INV_TWO_SIGMA_SQ);
        set_sizes(0, 4, 127);
        send_query(4);
        wait_idle();

        // Zero detector count, then oversized detector and single group
        set_sizes(4, 0, 3);
        send(OP_QUERY, 8'h00, 6'd0, near_value(), 1'b1);
        wait_idle();
        set_sizes(1, 31, 1);
        send_query(16);
        wait_idle();

        // No groups: run produces nothing
        set_sizes(4, 3, 0);
        send_query(3);
        wait_idle();

        // Random phases: a few loads plus a complete query, some noise
        nwr = 0;
        while (nwr < 12) begin
            cfg_write(REG_INV_TWO_SIGMA_SQ, ($urandom_range(0, 3) == 0) ? $urandom
                                            : $urandom_range(32'h1000, 32'h40_0000));
            set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0: send(OP_RESERVED, 8'($urandom), 6'($urandom), $urandom,
                            1'($urandom));
                    1: send(OP_QUERY, 8'($urandom), 6'($urandom), $urandom, 1'b0);
                    2, 3, 4: send(OP_FEATURE, 8'($urandom_range(0, 3)),
                                  6'($urandom_range(0, 20)), near_value(), 1'($urandom));
                    default: send(OP_TARGET, 8'($urandom_range(0, 3)), 6'($urandom),
                                  $urandom, 1'($urandom));
                endcase
                nwr++;
            end
            send_query(sh_det);
            nwr += (sh_det < 16) ? sh_det : 16;
            no_gaps = 1'b0;
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
